FILE: hdl/graph_traversal_engine_top_defines.svh
// assertion macros shared by the graph traversal engine rtl
// expects signals clk and rst_n in the including module
`ifndef GRAPH_TRAVERSAL_ENGINE_TOP_DEFINES_SVH
`define GRAPH_TRAVERSAL_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GTE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define GTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/gte_pkg.sv
// types and codes for the graph traversal engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gte_pkg;

    localparam int ID_W = 3;

    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_LIST     = 2'd1;
    localparam logic [1:0] CMD_TRAVERSE = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_ID  = 2'd2;
    localparam logic [1:0] ST_NO_NBRS = 2'd3;

    localparam logic [1:0] ORD_DFS_STACK = 2'd1;
    localparam logic [1:0] ORD_DFS_REC   = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
    localparam logic [OP_W-1:0] OP_EMIT_BAD   = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD_RDA    = 5'd3;
    localparam logic [OP_W-1:0] OP_ADD_FULL   = 5'd4;
    localparam logic [OP_W-1:0] OP_ADD_WA     = 5'd5;
    localparam logic [OP_W-1:0] OP_ADD_WB     = 5'd6;
    localparam logic [OP_W-1:0] OP_LIST_INIT  = 5'd7;
    localparam logic [OP_W-1:0] OP_LIST_EMPTY = 5'd8;
    localparam logic [OP_W-1:0] OP_ADJ_RD     = 5'd9;
    localparam logic [OP_W-1:0] OP_LIST_EMIT  = 5'd10;
    localparam logic [OP_W-1:0] OP_BFS_INIT   = 5'd11;
    localparam logic [OP_W-1:0] OP_BFS_POP    = 5'd12;
    localparam logic [OP_W-1:0] OP_LOAD_NODE  = 5'd13;
    localparam logic [OP_W-1:0] OP_BFS_CHK    = 5'd14;
    localparam logic [OP_W-1:0] OP_DFS_INIT   = 5'd15;
    localparam logic [OP_W-1:0] OP_DFS_POP    = 5'd16;
    localparam logic [OP_W-1:0] OP_DFS_VISIT  = 5'd17;
    localparam logic [OP_W-1:0] OP_DFS_CHK    = 5'd18;
    localparam logic [OP_W-1:0] OP_REC_INIT   = 5'd19;
    localparam logic [OP_W-1:0] OP_REC_POP    = 5'd20;
    localparam logic [OP_W-1:0] OP_REC_CHK    = 5'd21;
    localparam logic [OP_W-1:0] OP_REC_LOAD   = 5'd22;
    localparam logic [OP_W-1:0] OP_FINISH     = 5'd23;

    // which node id addresses the degree table
    localparam logic [2:0] DS_A     = 3'd0;
    localparam logic [2:0] DS_B     = 3'd1;
    localparam logic [2:0] DS_WORK  = 3'd2;
    localparam logic [2:0] DS_ADJ   = 3'd3;
    localparam logic [2:0] DS_FRAME = 3'd4;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic [1:0]      status;
        logic            last;
    } res_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [2:0]      deg_src;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] order;
        logic       bad;
        logic       full;
        logic       d_zero;
        logic       i_eq_d;
        logic       q_empty;
        logic       ptr_zero;
        logic       nb_seen;
        logic       top_seen;
        logic       depth_one;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/graph_traversal_engine_top.sv
// top level of the graph traversal engine
// depends on gte_pkg, gte_ctrl and gte_datapath
`timescale 1ns / 1ps
`default_nettype none
// A command is taken when start is high and busy low; busy stays high until every result
// of it has been issued. Results appear on result for one cycle each with strobe high and
// cannot be held off by the receiver. Add edge reads a's degree, checks both lists for
// room, writes b into the list of a and a into b's list. Listing emits each neighbour;
// a traversal reads each adjacency entry of each reached node from the single-port memory
// and checks it. Results trail each visit by one step so the final one carries last.
module graph_traversal_engine_top #(
    parameter int NODE_COUNT = 8,
    parameter int MAX_DEGREE = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire gte_pkg::req_t request,
    input  wire logic          order_we,
    input  wire logic [1:0]    order_wdata,
    output logic               strobe,
    output gte_pkg::res_t      result
);

    gte_pkg::dp_cmd_t    dp_cmd;
    gte_pkg::dp_status_t dp_sts;

    gte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (dp_sts),
        .cmd   (dp_cmd)
    );

    gte_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .order_we    (order_we),
        .order_wdata (order_wdata),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .strobe      (strobe),
        .result      (result)
    );

endmodule
`default_nettype wire

FILE: hdl/gte_ctrl.sv
// sequencing state machine of the graph traversal engine
// depends on gte_pkg
`timescale 1ns / 1ps
`default_nettype none
module gte_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire gte_pkg::dp_status_t sts,
    output gte_pkg::dp_cmd_t        cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_CHECK     = 5'd1;
    localparam logic [4:0] S_ADD_B     = 5'd2;
    localparam logic [4:0] S_ADD_WB    = 5'd3;
    localparam logic [4:0] S_LIST_RD   = 5'd4;
    localparam logic [4:0] S_LIST_EM   = 5'd5;
    localparam logic [4:0] S_BFS_POP   = 5'd6;
    localparam logic [4:0] S_BFS_LOAD  = 5'd7;
    localparam logic [4:0] S_BFS_RD    = 5'd8;
    localparam logic [4:0] S_BFS_CHK   = 5'd9;
    localparam logic [4:0] S_DFS_POP   = 5'd10;
    localparam logic [4:0] S_DFS_VIS   = 5'd11;
    localparam logic [4:0] S_DFS_RD    = 5'd12;
    localparam logic [4:0] S_DFS_CHK   = 5'd13;
    localparam logic [4:0] S_REC_STEP  = 5'd14;
    localparam logic [4:0] S_REC_CHK   = 5'd15;
    localparam logic [4:0] S_REC_LOAD  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_ADD_B, S_ADD_WB:     cmd.deg_src = gte_pkg::DS_B;
            S_BFS_LOAD, S_DFS_VIS: cmd.deg_src = gte_pkg::DS_WORK;
            S_REC_CHK:             cmd.deg_src = gte_pkg::DS_ADJ;
            S_REC_LOAD:            cmd.deg_src = gte_pkg::DS_FRAME;
            default:               cmd.deg_src = gte_pkg::DS_A;
        endcase
        cmd.op     = gte_pkg::OP_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = gte_pkg::OP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (sts.command == gte_pkg::CMD_NONE)
                begin
                    cmd.op = gte_pkg::OP_NONE;
                end
                else if (sts.bad)
                begin
                    cmd.op = gte_pkg::OP_EMIT_BAD;
                end
                else if (sts.command == gte_pkg::CMD_ADD_EDGE)
                begin
                    cmd.op     = gte_pkg::OP_ADD_RDA;
                    state_next = S_ADD_B;
                end
                else if (sts.command == gte_pkg::CMD_LIST)
                begin
                    cmd.op     = gte_pkg::OP_LIST_INIT;
                    state_next = S_LIST_RD;
                end
                else if (sts.order == gte_pkg::ORD_DFS_STACK)
                begin
                    cmd.op     = gte_pkg::OP_DFS_INIT;
                    state_next = S_DFS_POP;
                end
                else if (sts.order == gte_pkg::ORD_DFS_REC)
                begin
                    cmd.op     = gte_pkg::OP_REC_INIT;
                    state_next = S_REC_STEP;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_BFS_INIT;
                    state_next = S_BFS_POP;
                end
            end
            S_ADD_B:
            begin
                if (sts.full)
                begin
                    cmd.op     = gte_pkg::OP_ADD_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_ADD_WA;
                    state_next = S_ADD_WB;
                end
            end
            S_ADD_WB:
            begin
                cmd.op     = gte_pkg::OP_ADD_WB;
                state_next = S_IDLE;
            end
            S_LIST_RD:
            begin
                if (sts.d_zero)
                begin
                    cmd.op     = gte_pkg::OP_LIST_EMPTY;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_ADJ_RD;
                    state_next = S_LIST_EM;
                end
            end
            S_LIST_EM:
            begin
                cmd.op     = gte_pkg::OP_LIST_EMIT;
                state_next = sts.i_eq_d ? S_IDLE : S_LIST_RD;
            end
            S_BFS_POP:
            begin
                if (sts.q_empty)
                begin
                    cmd.op     = gte_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_BFS_POP;
                    state_next = S_BFS_LOAD;
                end
            end
            S_BFS_LOAD:
            begin
                cmd.op     = gte_pkg::OP_LOAD_NODE;
                state_next = S_BFS_RD;
            end
            S_BFS_RD:
            begin
                if (sts.i_eq_d)
                begin
                    state_next = S_BFS_POP;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_ADJ_RD;
                    state_next = S_BFS_CHK;
                end
            end
            S_BFS_CHK:
            begin
                cmd.op     = gte_pkg::OP_BFS_CHK;
                state_next = S_BFS_RD;
            end
            S_DFS_POP:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.op     = gte_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_DFS_POP;
                    state_next = S_DFS_VIS;
                end
            end
            S_DFS_VIS:
            begin
                if (sts.top_seen)
                begin
                    state_next = S_DFS_POP;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_DFS_VISIT;
                    state_next = S_DFS_RD;
                end
            end
            S_DFS_RD:
            begin
                if (sts.i_eq_d)
                begin
                    state_next = S_DFS_POP;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_ADJ_RD;
                    state_next = S_DFS_CHK;
                end
            end
            S_DFS_CHK:
            begin
                cmd.op     = gte_pkg::OP_DFS_CHK;
                state_next = S_DFS_RD;
            end
            S_REC_STEP:
            begin
                if (!sts.i_eq_d)
                begin
                    cmd.op     = gte_pkg::OP_ADJ_RD;
                    state_next = S_REC_CHK;
                end
                else if (sts.depth_one)
                begin
                    cmd.op     = gte_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = gte_pkg::OP_REC_POP;
                    state_next = S_REC_LOAD;
                end
            end
            S_REC_CHK:
            begin
                cmd.op     = gte_pkg::OP_REC_CHK;
                state_next = S_REC_STEP;
            end
            S_REC_LOAD:
            begin
                cmd.op     = gte_pkg::OP_REC_LOAD;
                state_next = S_REC_STEP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gte_datapath.sv
// adjacency store, degree table, work queue/stack, recursion frames and result register
// depends on gte_pkg and graph_traversal_engine_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "graph_traversal_engine_top_defines.svh"
module gte_datapath #(
    parameter int NODE_COUNT = 8,
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gte_pkg::req_t        request,
    input  wire logic                 order_we,
    input  wire logic [1:0]           order_wdata,
    input  wire gte_pkg::dp_cmd_t     cmd,
    output gte_pkg::dp_status_t       sts,
    output logic                      strobe,
    output gte_pkg::res_t             result
);

    localparam int ID_W       = gte_pkg::ID_W;
    localparam int ADJ_DEPTH  = NODE_COUNT * MAX_DEGREE;
    localparam int ADJ_AW     = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;
    localparam int WORK_DEPTH = ADJ_DEPTH + 1;
    localparam int WORK_AW    = $clog2(WORK_DEPTH);
    localparam int WORK_CW    = $clog2(WORK_DEPTH + 1);
    localparam int NI_W       = $clog2(NODE_COUNT);
    localparam int DEP_W      = $clog2(NODE_COUNT + 1);
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int FRAME_W    = ID_W + DEG_W;

    // control state
    logic [DEG_W-1:0]   deg_reg [NODE_COUNT];
    logic [NODE_COUNT-1:0] visited_reg;
    logic [1:0]         order_reg;
    logic               strobe_reg;
    logic               pend_valid_reg;
    logic [WORK_CW-1:0] head_reg;
    logic [WORK_CW-1:0] ptr_reg;
    logic [DEP_W-1:0]   depth_reg;
    logic [DEG_W-1:0]   i_reg;

    // payload
    logic [ID_W-1:0]    adj_mem [ADJ_DEPTH];
    logic [ID_W-1:0]    work_mem [WORK_DEPTH];
    logic [FRAME_W-1:0] frame_mem [NODE_COUNT];
    logic [ID_W-1:0]    adj_rd_reg;
    logic [ID_W-1:0]    work_rd_reg;
    logic [FRAME_W-1:0] frame_rd_reg;
    logic [1:0]         command_reg;
    logic [ID_W-1:0]    a_reg;
    logic [ID_W-1:0]    b_reg;
    logic [ID_W-1:0]    n_reg;
    logic [DEG_W-1:0]   d_reg;
    logic [DEG_W-1:0]   da_reg;
    logic [ID_W-1:0]    pend_id_reg;
    gte_pkg::res_t      result_reg;

    logic [ID_W-1:0]    deg_id;
    logic [DEG_W-1:0]   deg_rd;
    logic [ID_W-1:0]    frame_node;
    logic [DEG_W-1:0]   frame_cur;
    logic [ADJ_AW-1:0]  adj_rd_addr;
    logic [ADJ_AW-1:0]  adj_wa_addr;
    logic [ADJ_AW-1:0]  adj_wb_addr;
    logic               nb_seen;
    logic               visit_en;
    logic [ID_W-1:0]    visit_id;
    logic [NODE_COUNT-1:0] visit_mask;
    logic               emit_en;
    gte_pkg::res_t      emit_res;
    logic               init_op;

    assign frame_node = frame_rd_reg[FRAME_W-1 -: ID_W];
    assign frame_cur  = frame_rd_reg[DEG_W-1:0];

    // single read port on the degree table
    always_comb
    begin
        case (cmd.deg_src)
            gte_pkg::DS_B:     deg_id = b_reg;
            gte_pkg::DS_WORK:  deg_id = work_rd_reg;
            gte_pkg::DS_ADJ:   deg_id = adj_rd_reg;
            gte_pkg::DS_FRAME: deg_id = frame_node;
            default:           deg_id = a_reg;
        endcase
    end
    assign deg_rd = deg_reg[NI_W'(32'(deg_id))];

    assign adj_rd_addr = ADJ_AW'(32'(n_reg) * MAX_DEGREE + 32'(i_reg));
    assign adj_wa_addr = ADJ_AW'(32'(a_reg) * MAX_DEGREE + 32'(da_reg));
    assign adj_wb_addr = ADJ_AW'(32'(b_reg) * MAX_DEGREE + 32'(deg_rd));

    assign nb_seen = visited_reg[NI_W'(32'(adj_rd_reg))];

    assign sts.command   = command_reg;
    assign sts.order     = order_reg;
    assign sts.bad       = (32'(a_reg) >= NODE_COUNT) ||
                           ((command_reg == gte_pkg::CMD_ADD_EDGE) &&
                            (32'(b_reg) >= NODE_COUNT));
    // a self-loop needs two free slots in one list
    assign sts.full      = (32'(da_reg) + ((a_reg == b_reg) ? 32'd2 : 32'd1) > MAX_DEGREE) ||
                           (32'(deg_rd) + 32'd1 > MAX_DEGREE);
    assign sts.d_zero    = (d_reg == '0);
    assign sts.i_eq_d    = (i_reg == d_reg);
    assign sts.q_empty   = (head_reg == ptr_reg);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.nb_seen   = nb_seen;
    assign sts.top_seen  = visited_reg[NI_W'(32'(work_rd_reg))];
    assign sts.depth_one = (depth_reg == DEP_W'(1));

    assign init_op = (cmd.op == gte_pkg::OP_BFS_INIT) || (cmd.op == gte_pkg::OP_DFS_INIT) ||
                     (cmd.op == gte_pkg::OP_REC_INIT);

    assign visit_mask = NODE_COUNT'(1) << visit_id;

    // visits go out one behind, so the final one can carry last
    always_comb
    begin
        visit_en = 1'b0;
        visit_id = a_reg;
        emit_en  = 1'b0;
        emit_res = '0;
        case (cmd.op)
            gte_pkg::OP_BFS_INIT, gte_pkg::OP_REC_INIT:
            begin
                visit_en = 1'b1;
            end
            gte_pkg::OP_BFS_CHK, gte_pkg::OP_REC_CHK:
            begin
                visit_en = !nb_seen;
                visit_id = adj_rd_reg;
            end
            gte_pkg::OP_DFS_VISIT:
            begin
                visit_en = 1'b1;
                visit_id = work_rd_reg;
            end
            gte_pkg::OP_EMIT_BAD:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: '0, status: gte_pkg::ST_BAD_ID, last: 1'b1};
            end
            gte_pkg::OP_ADD_FULL:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: '0, status: gte_pkg::ST_FULL, last: 1'b1};
            end
            gte_pkg::OP_ADD_WB:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: '0, status: gte_pkg::ST_OK, last: 1'b1};
            end
            gte_pkg::OP_LIST_EMPTY:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: '0, status: gte_pkg::ST_NO_NBRS, last: 1'b1};
            end
            gte_pkg::OP_LIST_EMIT:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: adj_rd_reg, status: gte_pkg::ST_OK, last: sts.i_eq_d};
            end
            gte_pkg::OP_FINISH:
            begin
                emit_en  = 1'b1;
                emit_res = '{node_id: pend_id_reg, status: gte_pkg::ST_OK, last: 1'b1};
            end
            default:
            begin
                visit_en = 1'b0;
            end
        endcase
        if (visit_en && pend_valid_reg)
        begin
            emit_en  = 1'b1;
            emit_res = '{node_id: pend_id_reg, status: gte_pkg::ST_OK, last: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NODE_COUNT; k++)
            begin
                deg_reg[k] <= '0;
            end
            visited_reg    <= '0;
            order_reg      <= '0;
            strobe_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            head_reg       <= '0;
            ptr_reg        <= '0;
            depth_reg      <= '0;
            i_reg          <= '0;
        end
        else
        begin
            if (order_we)
            begin
                order_reg <= order_wdata;
            end
            strobe_reg <= emit_en;
            // a traversal start clears the marks and may mark the start node
            if (init_op)
            begin
                visited_reg <= visit_en ? visit_mask : '0;
            end
            else if (visit_en)
            begin
                visited_reg <= visited_reg | visit_mask;
            end
            if (cmd.op == gte_pkg::OP_FINISH)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (visit_en)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (init_op)
            begin
                pend_valid_reg <= 1'b0;
            end
            case (cmd.op)
                gte_pkg::OP_ADD_WA:
                begin
                    deg_reg[NI_W'(32'(a_reg))] <= da_reg + DEG_W'(1);
                end
                gte_pkg::OP_ADD_WB:
                begin
                    deg_reg[NI_W'(32'(b_reg))] <= deg_rd + DEG_W'(1);
                end
                gte_pkg::OP_LIST_INIT:
                begin
                    i_reg <= '0;
                end
                gte_pkg::OP_ADJ_RD:
                begin
                    i_reg <= i_reg + DEG_W'(1);
                end
                gte_pkg::OP_BFS_INIT:
                begin
                    head_reg <= '0;
                    ptr_reg  <= WORK_CW'(1);
                end
                gte_pkg::OP_DFS_INIT:
                begin
                    ptr_reg <= WORK_CW'(1);
                end
                gte_pkg::OP_BFS_POP:
                begin
                    head_reg <= head_reg + WORK_CW'(1);
                end
                gte_pkg::OP_LOAD_NODE, gte_pkg::OP_DFS_VISIT:
                begin
                    i_reg <= '0;
                end
                gte_pkg::OP_BFS_CHK, gte_pkg::OP_DFS_CHK:
                begin
                    if (!nb_seen)
                    begin
                        ptr_reg <= ptr_reg + WORK_CW'(1);
                    end
                end
                gte_pkg::OP_DFS_POP:
                begin
                    ptr_reg <= ptr_reg - WORK_CW'(1);
                end
                gte_pkg::OP_REC_INIT:
                begin
                    i_reg     <= '0;
                    depth_reg <= DEP_W'(1);
                end
                gte_pkg::OP_REC_CHK:
                begin
                    if (!nb_seen)
                    begin
                        i_reg     <= '0;
                        depth_reg <= depth_reg + DEP_W'(1);
                    end
                end
                gte_pkg::OP_REC_POP:
                begin
                    depth_reg <= depth_reg - DEP_W'(1);
                end
                gte_pkg::OP_REC_LOAD:
                begin
                    i_reg <= frame_cur;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            result_reg <= emit_res;
        end
        if (visit_en)
        begin
            pend_id_reg <= visit_id;
        end
        case (cmd.op)
            gte_pkg::OP_LATCH:
            begin
                command_reg <= request.command;
                a_reg       <= request.node_a;
                b_reg       <= request.node_b;
            end
            gte_pkg::OP_ADD_RDA:
            begin
                da_reg <= deg_rd;
            end
            gte_pkg::OP_ADD_WA:
            begin
                adj_mem[adj_wa_addr] <= b_reg;
            end
            gte_pkg::OP_ADD_WB:
            begin
                adj_mem[adj_wb_addr] <= a_reg;
            end
            gte_pkg::OP_LIST_INIT, gte_pkg::OP_REC_INIT:
            begin
                n_reg <= a_reg;
                d_reg <= deg_rd;
            end
            gte_pkg::OP_ADJ_RD:
            begin
                adj_rd_reg <= adj_mem[adj_rd_addr];
            end
            gte_pkg::OP_BFS_INIT, gte_pkg::OP_DFS_INIT:
            begin
                work_mem[0] <= a_reg;
            end
            gte_pkg::OP_BFS_POP:
            begin
                work_rd_reg <= work_mem[head_reg[WORK_AW-1:0]];
            end
            gte_pkg::OP_DFS_POP:
            begin
                work_rd_reg <= work_mem[WORK_AW'(ptr_reg - WORK_CW'(1))];
            end
            gte_pkg::OP_LOAD_NODE, gte_pkg::OP_DFS_VISIT:
            begin
                n_reg <= work_rd_reg;
                d_reg <= deg_rd;
            end
            gte_pkg::OP_BFS_CHK, gte_pkg::OP_DFS_CHK:
            begin
                if (!nb_seen)
                begin
                    work_mem[ptr_reg[WORK_AW-1:0]] <= adj_rd_reg;
                end
            end
            gte_pkg::OP_REC_CHK:
            begin
                if (!nb_seen)
                begin
                    // save the caller frame with its advanced cursor
                    frame_mem[NI_W'(depth_reg - DEP_W'(1))] <= {n_reg, i_reg};
                    n_reg <= adj_rd_reg;
                    d_reg <= deg_rd;
                end
            end
            gte_pkg::OP_REC_POP:
            begin
                frame_rd_reg <= frame_mem[NI_W'(depth_reg - DEP_W'(2))];
            end
            gte_pkg::OP_REC_LOAD:
            begin
                n_reg <= frame_node;
                d_reg <= deg_rd;
            end
            default:
            begin
                da_reg <= da_reg;
            end
        endcase
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `GTE_ASSERT_IMPLY(a_err_is_last, strobe_reg && result_reg.status != gte_pkg::ST_OK,
        result_reg.last)
    `GTE_ASSERT_IMPLY(a_err_zero_id, strobe_reg && result_reg.status != gte_pkg::ST_OK,
        result_reg.node_id == '0)
    `GTE_ASSERT_IMPLY(a_finish_pending, cmd.op == gte_pkg::OP_FINISH, pend_valid_reg)
    `GTE_ASSERT_NEXT(a_bad_emits, cmd.op == gte_pkg::OP_EMIT_BAD,
        strobe_reg && result_reg.status == gte_pkg::ST_BAD_ID)

endmodule
`default_nettype wire
